@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/i2cms_pkg.sv @@
package i2cms_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_MTX   = 2'd1,
    PH_MRX   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_START_WR = 2'd1,
    REQ_START_RD = 2'd2,
    REQ_EVENT    = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_ADDR     = 4'd1,
    ACT_DATA     = 4'd2,
    ACT_ACK      = 4'd3,
    ACT_NACK     = 4'd4,
    ACT_STOP     = 4'd5,
    ACT_RELEASE  = 4'd6,
    ACT_START    = 4'd7,
    ACT_DIRECT   = 4'd8,
    ACT_REPSTART = 4'd9
  } act_t;

  typedef enum logic [2:0] {
    RC_OK        = 3'd0,
    RC_LONG      = 3'd1,
    RC_ADDR_NACK = 3'd2,
    RC_DATA_NACK = 3'd3,
    RC_OTHER     = 3'd4,
    RC_BUSY      = 3'd5
  } rc_t;

  // Bus engine status codes (low three bits masked off)
  localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_REP_START    = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;
  localparam logic [7:0] ST_MASK         = 8'hF8;

  typedef struct packed {
    act_t             act;
    logic [7:0]       out_byte;
    logic             use_ram;
    logic             rxv;
    logic [7:0]       rx;
    logic             done;
    rc_t              code;
    logic [CNT_W-1:0] cnt;
    logic             busy;
  } res_t;

endpackage

@@ src/i2cms_ram.sv @@
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/i2c_master_transaction_sequencer_core.sv @@
// The result is valid on the master side in the cycle after the request is accepted.
// Throughput: one request per cycle while the result side does not stall, set by the
//   update of the control registers on each accept and the one read port of the transmit store.
// Reset (rst, synchronous, active high) clears phase, counters, flags and the
//   output valid; the transmit store is not cleared and takes no clearing pass.
module i2c_master_transaction_sequencer_core
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        s_tvalid,
  output logic        s_tready,
  // [6:0] dev_address, [14:7] xfer_length, [15] end_with_stop,
  // [23:16] wr_byte, [31:24] bus_status, [39:32] bus_byte_in
  input  logic [39:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] bus_byte_out, [15:8] rx_byte, [16] done_res, [19:17] result_code,
  // [25:20] rx_count, [26] busy_res, [31:27] zero
  output logic [31:0] m_tdata,
  // [3:0] bus_action, [4] rx_valid
  output logic [4:0]  m_tuser
);

  // Request fields
  req_t             req_type;
  logic [6:0]       dev_address;
  logic [7:0]       xfer_length;
  logic             end_with_stop;
  logic [7:0]       wr_byte;
  logic [7:0]       bus_status;
  logic [7:0]       bus_byte_in;

  assign req_type      = req_t'(s_tuser);
  assign dev_address   = s_tdata[6:0];
  assign xfer_length   = s_tdata[14:7];
  assign end_with_stop = s_tdata[15];
  assign wr_byte       = s_tdata[23:16];
  assign bus_status    = s_tdata[31:24];
  assign bus_byte_in   = s_tdata[39:32];

  // Control state
  phase_t           phase, phase_next;
  logic [7:0]       addr_dir_byte, addr_dir_byte_next;
  logic             stop_at_end, stop_at_end_next;
  logic             in_repeated_start, in_repeated_start_next;
  logic [CNT_W-1:0] byte_index, byte_index_next;
  logic [CNT_W-1:0] byte_limit, byte_limit_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  rc_t              error_kind, error_kind_next;

  // Result register
  res_t             res, res_next;

  // Transmit store port
  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;

  logic             s_acc;
  logic             active;
  logic [7:0]       st;
  logic             len_bad;
  logic             store_full;
  logic             tx_more;
  logic             rx_take;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_after;
  logic             ack_after_data;
  logic             ack_after_sla;

  // Accept a request whenever the result register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;

  assign active     = (phase != PH_READY);
  assign st         = bus_status & ST_MASK;
  assign len_bad    = (xfer_length > 8'(BUF_DEPTH));
  assign store_full = (fill_count >= CNT_W'(BUF_DEPTH));
  assign idx_inc    = byte_index + 1'b1;
  assign tx_more    = (byte_index < byte_limit) && (byte_index < CNT_W'(BUF_DEPTH));
  assign rx_take    = (byte_index < byte_limit);
  assign idx_after  = rx_take ? idx_inc : byte_index;

  // ACK when at least one more byte is wanted after the next one
  assign ack_after_data = ({1'b0, idx_after} + 1'b1) < {1'b0, byte_limit};
  assign ack_after_sla  = ({1'b0, byte_index} + 1'b1) < {1'b0, byte_limit};

  // Next-state logic for the sequencer
  always_comb begin
    phase_next             = phase;
    addr_dir_byte_next     = addr_dir_byte;
    stop_at_end_next       = stop_at_end;
    in_repeated_start_next = in_repeated_start;
    byte_index_next        = byte_index;
    byte_limit_next        = byte_limit;
    fill_count_next        = fill_count;
    error_kind_next        = error_kind;
    case (req_type)
      REQ_LOAD: begin
        if (!active && !store_full) begin
          fill_count_next = fill_count + 1'b1;
        end
      end
      REQ_START_WR, REQ_START_RD: begin
        if (!len_bad && !active) begin
          phase_next             = (req_type == REQ_START_RD) ? PH_MRX : PH_MTX;
          stop_at_end_next       = end_with_stop;
          error_kind_next        = RC_OK;
          byte_index_next        = '0;
          byte_limit_next        = xfer_length[CNT_W-1:0];
          addr_dir_byte_next     = {dev_address, (req_type == REQ_START_RD)};
          in_repeated_start_next = 1'b0;
          if (req_type == REQ_START_WR) begin
            fill_count_next = '0;
          end
        end
      end
      REQ_EVENT: begin
        if (active) begin
          case (st)
            ST_START, ST_REP_START: begin
            end
            ST_ARB_LOST, ST_BUS_ERROR: begin
              phase_next      = PH_READY;
              error_kind_next = RC_OTHER;
            end
            default: begin
              if (phase == PH_MTX) begin
                case (st)
                  ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                    if (tx_more) begin
                      byte_index_next = idx_inc;
                    end else begin
                      phase_next = PH_READY;
                      if (!stop_at_end) begin
                        in_repeated_start_next = 1'b1;
                      end
                    end
                  end
                  ST_MT_SLA_NACK: begin
                    phase_next      = PH_READY;
                    error_kind_next = RC_ADDR_NACK;
                  end
                  ST_MT_DATA_NACK: begin
                    phase_next      = PH_READY;
                    error_kind_next = RC_DATA_NACK;
                  end
                  default: begin
                  end
                endcase
              end else begin
                case (st)
                  ST_MR_DATA_ACK: begin
                    byte_index_next = idx_after;
                  end
                  ST_MR_DATA_NACK: begin
                    byte_index_next = idx_after;
                    phase_next      = PH_READY;
                    if (!stop_at_end) begin
                      in_repeated_start_next = 1'b1;
                    end
                  end
                  ST_MR_SLA_NACK: begin
                    phase_next      = PH_READY;
                    error_kind_next = RC_OK;
                  end
                  default: begin
                  end
                endcase
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Result and store-access logic
  always_comb begin
    res_next          = '0;
    res_next.act      = ACT_NONE;
    res_next.code     = RC_OK;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    case (req_type)
      REQ_LOAD: begin
        res_next.done = 1'b1;
        if (active) begin
          res_next.code = RC_BUSY;
        end else if (store_full) begin
          res_next.code = RC_LONG;
        end else begin
          ram_we = s_acc;
        end
      end
      REQ_START_WR, REQ_START_RD: begin
        if (len_bad) begin
          res_next.done = 1'b1;
          res_next.code = RC_LONG;
        end else if (active) begin
          res_next.done = 1'b1;
          res_next.code = RC_BUSY;
        end else if (in_repeated_start) begin
          res_next.act      = ACT_DIRECT;
          res_next.out_byte = {dev_address, (req_type == REQ_START_RD)};
        end else begin
          res_next.act = ACT_START;
        end
      end
      REQ_EVENT: begin
        if (active) begin
          case (st)
            ST_START, ST_REP_START: begin
              res_next.act      = ACT_ADDR;
              res_next.out_byte = addr_dir_byte;
            end
            ST_ARB_LOST: begin
              res_next.act  = ACT_RELEASE;
              res_next.done = 1'b1;
              res_next.code = RC_OTHER;
              if (phase == PH_MRX) begin
                res_next.cnt = byte_index;
              end
            end
            ST_BUS_ERROR: begin
              res_next.act  = ACT_STOP;
              res_next.done = 1'b1;
              res_next.code = RC_OTHER;
              if (phase == PH_MRX) begin
                res_next.cnt = byte_index;
              end
            end
            default: begin
              if (phase == PH_MTX) begin
                case (st)
                  ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
                    if (tx_more) begin
                      // data byte is read from the store on accept and reaches the output with the result
                      res_next.act     = ACT_DATA;
                      res_next.use_ram = 1'b1;
                      ram_re           = s_acc;
                    end else begin
                      res_next.act  = stop_at_end ? ACT_STOP : ACT_REPSTART;
                      res_next.done = 1'b1;
                      res_next.code = error_kind;
                    end
                  end
                  ST_MT_SLA_NACK: begin
                    res_next.act  = ACT_STOP;
                    res_next.done = 1'b1;
                    res_next.code = RC_ADDR_NACK;
                  end
                  ST_MT_DATA_NACK: begin
                    res_next.act  = ACT_STOP;
                    res_next.done = 1'b1;
                    res_next.code = RC_DATA_NACK;
                  end
                  default: begin
                  end
                endcase
              end else begin
                case (st)
                  ST_MR_DATA_ACK: begin
                    res_next.rxv = rx_take;
                    res_next.rx  = rx_take ? bus_byte_in : 8'h00;
                    res_next.act = ack_after_data ? ACT_ACK : ACT_NACK;
                  end
                  ST_MR_SLA_ACK: begin
                    res_next.act = ack_after_sla ? ACT_ACK : ACT_NACK;
                  end
                  ST_MR_DATA_NACK: begin
                    res_next.rxv  = rx_take;
                    res_next.rx   = rx_take ? bus_byte_in : 8'h00;
                    res_next.act  = stop_at_end ? ACT_STOP : ACT_REPSTART;
                    res_next.done = 1'b1;
                    res_next.code = error_kind;
                    res_next.cnt  = idx_after;
                  end
                  ST_MR_SLA_NACK: begin
                    res_next.act  = ACT_STOP;
                    res_next.done = 1'b1;
                    res_next.code = RC_OK;
                    res_next.cnt  = byte_index;
                  end
                  default: begin
                  end
                endcase
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    res_next.busy = (phase_next != PH_READY);
  end

  // Transmit store: loads write at the fill point, transmit reads at the
  // byte index. Loads happen only when idle and reads only while
  // transmitting, so the two never touch the store in the same cycle.
  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_tx_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[BUF_AW-1:0]),
    .wdata (wr_byte),
    .re    (ram_re),
    .raddr (byte_index[BUF_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Advance control state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_READY;
      addr_dir_byte     <= '0;
      stop_at_end       <= 1'b0;
      in_repeated_start <= 1'b0;
      byte_index        <= '0;
      byte_limit        <= '0;
      fill_count        <= '0;
      error_kind        <= RC_OK;
    end else if (s_acc) begin
      phase             <= phase_next;
      addr_dir_byte     <= addr_dir_byte_next;
      stop_at_end       <= stop_at_end_next;
      in_repeated_start <= in_repeated_start_next;
      byte_index        <= byte_index_next;
      byte_limit        <= byte_limit_next;
      fill_count        <= fill_count_next;
      error_kind        <= error_kind_next;
    end
  end

  // Output valid: set on accept, drop when taken without a new request
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result payload while the downstream stalls
  always_ff @(posedge clk) begin
    if (s_acc) begin
      res <= res_next;
    end
  end

  logic [7:0] out_byte;
  assign out_byte = res.use_ram ? ram_rdata : res.out_byte;

  assign m_tdata = {5'b0, res.busy, res.cnt, res.code, res.done, res.rx, out_byte};
  assign m_tuser = {res.rxv, res.act};

`include "assert_macros.svh"

  `CHK_NOW(a_fill_bound, 1'b1, fill_count <= CNT_W'(BUF_DEPTH), "fill count above store depth")
  `CHK_NOW(a_idx_bound, phase != PH_READY, byte_index <= byte_limit, "byte index past limit")
  `CHK_NOW(a_ram_rd_phase, ram_re, phase == PH_MTX && !ram_we, "store read outside transmit")
  `CHK_NEXT(a_data_from_ram, ram_re, m_tvalid && res.use_ram && res.act == ACT_DATA,
            "store read without data result")

endmodule

@@ tb/tb_i2c_master_transaction_sequencer_core.sv @@
module tb_i2c_master_transaction_sequencer_core
  import i2cms_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One request as the sender builds it, before packing onto the stream.
  typedef struct {
    req_t       kind;
    logic [6:0] addr;
    logic [7:0] len;
    logic       stop;
    logic [7:0] wr_byte;
    logic [7:0] status;
    logic [7:0] rx_in;
  } bus_request_t;

  // One result as the block should present it.
  typedef struct packed {
    act_t       act;
    logic [7:0] out_byte;
    logic       rxv;
    logic [7:0] rx;
    logic       done;
    rc_t        code;
    logic [5:0] cnt;
    logic       busy;
  } bus_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [6:0] dev_address, [14:7] xfer_length, [15] end_with_stop,
  // [23:16] wr_byte, [31:24] bus_status, [39:32] bus_byte_in
  logic [39:0] s_tdata = '0;
  // [1:0] req_type
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] bus_byte_out, [15:8] rx_byte, [16] done_res, [19:17] result_code,
  // [25:20] rx_count, [26] busy_res, [31:27] zero
  logic [31:0] m_tdata;
  // [3:0] bus_action, [4] rx_valid
  logic [4:0]  m_tuser;

  // Shadow copy of the sequencer state, advanced once per accepted request.
  phase_t     seq_phase = PH_READY;
  logic [7:0] addr_dir_q = '0;
  logic       stop_q = 1'b0;
  logic       rep_start_held = 1'b0;
  int         xfer_idx = 0;
  int         xfer_limit = 0;
  int         fill_cnt = 0;
  // Entries below this mark have been loaded at least once since reset.
  int         loaded_hwm = 0;
  rc_t        err_kind = RC_OK;
  logic [7:0] tx_mem [BUF_DEPTH];

  bus_resp_t  pending_responses[$];
  act_t       last_bus_action = ACT_NONE;
  int         effective_reqs = 0;
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  i2c_master_transaction_sequencer_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // End the transaction: report the bus action and code, and on a read also
  // the byte count reached so far.
  function automatic void close_xfer(inout bus_resp_t o, input act_t a, input rc_t c);
    if (seq_phase == PH_MRX)
      o.cnt = 6'(xfer_idx);
    err_kind  = c;
    o.act     = a;
    o.done    = 1'b1;
    o.code    = c;
    seq_phase = PH_READY;
  endfunction

  // Normal end: stop, or hold the repeated start so the next start goes
  // straight to the address.
  function automatic void close_normal(inout bus_resp_t o);
    if (stop_q) begin
      close_xfer(o, ACT_STOP, err_kind);
    end else begin
      rep_start_held = 1'b1;
      close_xfer(o, ACT_REPSTART, err_kind);
    end
  endfunction

  // Report a read byte only while the requested length is not yet reached.
  function automatic void capture_rx(inout bus_resp_t o, input logic [7:0] b);
    if (xfer_idx < xfer_limit) begin
      o.rxv = 1'b1;
      o.rx  = b;
      xfer_idx++;
    end
  endfunction

  function automatic bus_resp_t compute_bus_response(bus_request_t r);
    bus_resp_t  o;
    logic       dir;
    logic [7:0] st;
    o   = '0;
    dir = (r.kind == REQ_START_RD);
    st  = r.status & ST_MASK;
    case (r.kind)
      REQ_LOAD: begin
        o.done = 1'b1;
        if (seq_phase != PH_READY) begin
          o.code = RC_BUSY;
        end else if (fill_cnt >= BUF_DEPTH) begin
          o.code = RC_LONG;
        end else begin
          tx_mem[fill_cnt] = r.wr_byte;
          fill_cnt++;
          if (fill_cnt > loaded_hwm)
            loaded_hwm = fill_cnt;
        end
      end
      REQ_START_WR, REQ_START_RD: begin
        o.done = 1'b1;
        // Length is checked ahead of busy.
        if (r.len > BUF_DEPTH) begin
          o.code = RC_LONG;
        end else if (seq_phase != PH_READY) begin
          o.code = RC_BUSY;
        end else begin
          o.done     = 1'b0;
          seq_phase  = dir ? PH_MRX : PH_MTX;
          stop_q     = r.stop;
          err_kind   = RC_OK;
          xfer_idx   = 0;
          xfer_limit = r.len;
          addr_dir_q = {r.addr, dir};
          if (!dir)
            fill_cnt = 0;
          if (rep_start_held) begin
            rep_start_held = 1'b0;
            o.act      = ACT_DIRECT;
            o.out_byte = addr_dir_q;
          end else begin
            o.act = ACT_START;
          end
        end
      end
      default: begin
        // Bus events only matter while a transaction is open.
        if (seq_phase != PH_READY) begin
          if (st == ST_START || st == ST_REP_START) begin
            o.act      = ACT_ADDR;
            o.out_byte = addr_dir_q;
          end else if (st == ST_ARB_LOST) begin
            close_xfer(o, ACT_RELEASE, RC_OTHER);
          end else if (st == ST_BUS_ERROR) begin
            close_xfer(o, ACT_STOP, RC_OTHER);
          end else if (seq_phase == PH_MTX) begin
            if (st == ST_MT_SLA_ACK || st == ST_MT_DATA_ACK) begin
              if (xfer_idx < xfer_limit && xfer_idx < BUF_DEPTH) begin
                o.act      = ACT_DATA;
                o.out_byte = tx_mem[xfer_idx];
                xfer_idx++;
              end else begin
                close_normal(o);
              end
            end else if (st == ST_MT_SLA_NACK) begin
              close_xfer(o, ACT_STOP, RC_ADDR_NACK);
            end else if (st == ST_MT_DATA_NACK) begin
              close_xfer(o, ACT_STOP, RC_DATA_NACK);
            end
          end else begin
            if (st == ST_MR_DATA_ACK) begin
              capture_rx(o, r.rx_in);
              o.act = (xfer_idx + 1 < xfer_limit) ? ACT_ACK : ACT_NACK;
            end else if (st == ST_MR_SLA_ACK) begin
              o.act = (xfer_idx + 1 < xfer_limit) ? ACT_ACK : ACT_NACK;
            end else if (st == ST_MR_DATA_NACK) begin
              capture_rx(o, r.rx_in);
              close_normal(o);
            end else if (st == ST_MR_SLA_NACK) begin
              close_xfer(o, ACT_STOP, RC_OK);
            end
          end
        end
      end
    endcase
    o.busy = (seq_phase != PH_READY);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Present one request, hold it until accepted, then log its expected result.
  // Entered and left at a rising edge.
  task automatic send_request(bus_request_t r);
    int        gap;
    bus_resp_t exp_resp;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {r.rx_in, r.status, r.wr_byte, r.stop, r.len, r.addr};
    do @(posedge clk); while (!s_tready);
    exp_resp = compute_bus_response(r);
    pending_responses.push_back(exp_resp);
    if (exp_resp.act != ACT_NONE)
      last_bus_action = exp_resp.act;
    if (exp_resp.act != ACT_NONE || exp_resp.done)
      effective_reqs++;
  endtask

  // Fill every field at random so unused bits toggle too.
  function automatic bus_request_t random_request(req_t k);
    bus_request_t r;
    r.kind    = k;
    r.addr    = 7'($urandom);
    r.len     = 8'($urandom);
    r.stop    = 1'($urandom);
    r.wr_byte = 8'($urandom);
    r.status  = 8'($urandom);
    r.rx_in   = 8'($urandom);
    return r;
  endfunction

  task automatic send_load(logic [7:0] b);
    bus_request_t r;
    r = random_request(REQ_LOAD);
    r.wr_byte = b;
    send_request(r);
  endtask

  task automatic send_start(req_t k, logic [6:0] addr, logic [7:0] len, logic stop);
    bus_request_t r;
    r = random_request(k);
    r.addr = addr;
    r.len  = len;
    r.stop = stop;
    send_request(r);
  endtask

  task automatic send_event(logic [7:0] st, logic [7:0] b);
    bus_request_t r;
    r = random_request(REQ_EVENT);
    r.status = st;
    r.rx_in  = b;
    send_request(r);
  endtask

  // Pick the status the bus engine would report next, with some noise mixed
  // in. Low three bits are random since the block masks them.
  function automatic logic [7:0] next_status(int noise_pct);
    logic [7:0] st;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < noise_pct) begin
      if ($urandom_range(0, 1))
        st = 8'($urandom) & ST_MASK;
      else
        // master status codes step by eight from bus error to read data nack
        st = 8'($urandom_range(0, 11)) << 3;
    end else begin
      case (last_bus_action)
        ACT_START:
          st = $urandom_range(0, 1) ? ST_START : ST_REP_START;
        ACT_ADDR, ACT_DIRECT: begin
          if (seq_phase == PH_MTX)
            st = (pick % 10 == 0) ? ST_MT_SLA_NACK : ST_MT_SLA_ACK;
          else
            st = (pick % 10 == 0) ? ST_MR_SLA_NACK : ST_MR_SLA_ACK;
        end
        ACT_DATA:
          st = (pick % 20 == 0) ? ST_MT_DATA_NACK : ST_MT_DATA_ACK;
        ACT_ACK:
          st = (pick % 25 == 0) ? ST_ARB_LOST : ST_MR_DATA_ACK;
        ACT_NACK:
          st = ST_MR_DATA_NACK;
        default:
          st = 8'($urandom_range(0, 11)) << 3;
      endcase
    end
    // Never let a write fetch a store entry that was never loaded.
    if (seq_phase == PH_MTX && (st == ST_MT_SLA_ACK || st == ST_MT_DATA_ACK) &&
        xfer_idx < xfer_limit && xfer_idx >= loaded_hwm)
      st = ST_MT_DATA_NACK;
    return st | 8'($urandom_range(0, 7));
  endfunction

  // Play bus events until the open transaction closes; force a bus error if
  // noise keeps it going too long.
  task automatic drive_bus_events();
    int steps;
    steps = 0;
    while (seq_phase != PH_READY) begin
      if (steps > 60)
        send_event(ST_BUS_ERROR, 8'($urandom));
      else
        send_event(next_status(6), 8'($urandom));
      steps++;
    end
  endtask

  task automatic run_write_xfer();
    int         n;
    logic [7:0] len;
    n = $urandom_range(0, 6);
    repeat (n) send_load(8'($urandom));
    if ($urandom_range(0, 9) == 0)
      len = 8'($urandom);
    else
      len = 8'($urandom_range(0, loaded_hwm));
    send_start(REQ_START_WR, 7'($urandom), len, 1'($urandom));
    drive_bus_events();
  endtask

  task automatic run_read_xfer();
    logic [7:0] len;
    if ($urandom_range(0, 9) == 0)
      len = 8'($urandom);
    else
      len = 8'($urandom_range(0, BUF_DEPTH));
    send_start(REQ_START_RD, 7'($urandom), len, 1'($urandom));
    drive_bus_events();
  endtask

  task automatic send_noise();
    bus_request_t r;
    r = random_request(req_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 1))
      r.len = 8'($urandom_range(0, BUF_DEPTH));
    r.status = next_status(100);
    send_request(r);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  always @(posedge clk)
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    bus_resp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_responses.size() == 0) begin
        $error("unrequested result: tdata %h tuser %h", m_tdata, m_tuser);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("bus_action",   want.act,      m_tuser[3:0]);
        check_field("rx_valid",     want.rxv,      m_tuser[4]);
        check_field("bus_byte_out", want.out_byte, m_tdata[7:0]);
        check_field("rx_byte",      want.rx,       m_tdata[15:8]);
        check_field("done_res",     want.done,     m_tdata[16]);
        check_field("result_code",  want.code,     m_tdata[19:17]);
        check_field("rx_count",     want.cnt,      m_tdata[25:20]);
        check_field("busy_res",     want.busy,     m_tdata[26]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Load a few bytes and write them out with stop; extreme byte values,
  // highest address, masked low status bits.
  task automatic test_write_path();
    send_load(8'hFF);
    send_load(8'h00);
    send_load(8'hA5);
    send_start(REQ_START_WR, 7'h7F, 8'd3, 1'b1);
    send_event(ST_START, 8'h00);
    send_event(ST_MT_SLA_ACK | 8'h07, 8'hFF);
    send_event(ST_MT_DATA_ACK, 8'h00);
    send_event(ST_MT_DATA_ACK | 8'h05, 8'h00);
    send_event(ST_MT_DATA_ACK, 8'h00);
  endtask

  // Oversized and busy refusals, then a zero-length read ending in a held
  // repeated start.
  task automatic test_refusals_and_zero_read();
    send_start(REQ_START_WR, 7'h00, 8'd33, 1'b1);
    send_start(REQ_START_RD, 7'h7F, 8'hFF, 1'b0);
    send_start(REQ_START_RD, 7'h00, 8'd0, 1'b0);
    send_start(REQ_START_WR, 7'h12, 8'd1, 1'b1);
    send_start(REQ_START_WR, 7'h12, 8'd40, 1'b1);
    send_load(8'h5A);
    send_event(ST_REP_START, 8'h00);
    // transmit code during a read: ignore
    send_event(ST_MT_DATA_ACK, 8'h00);
    send_event(ST_MR_SLA_ACK, 8'h00);
    // the nacked byte is not reported for a zero-length read
    send_event(ST_MR_DATA_NACK, 8'hFF);
  endtask

  // Direct address after a held repeated start, read aborted by bus error,
  // idle event, arbitration loss, address nack on write and on read.
  task automatic test_repeated_start_and_errors();
    send_start(REQ_START_RD, 7'h55, 8'd2, 1'b1);
    send_event(ST_MR_SLA_ACK, 8'h00);
    send_event(ST_MR_DATA_ACK, 8'h3C);
    send_event(ST_BUS_ERROR, 8'h00);
    send_event(ST_MT_SLA_ACK, 8'h00);
    send_start(REQ_START_WR, 7'h2A, 8'd0, 1'b1);
    send_event(ST_ARB_LOST, 8'h00);
    send_start(REQ_START_WR, 7'h01, 8'd1, 1'b1);
    send_event(ST_MT_SLA_NACK, 8'h00);
    send_start(REQ_START_RD, 7'h00, 8'd1, 1'b1);
    send_event(ST_MR_SLA_NACK, 8'h00);
  endtask

  // Mostly well-formed transactions with random content, some noise, and the
  // odd burst that fills the store past its depth.
  task automatic test_random_traffic(int send_pct, int recv_pct, int quota);
    int target;
    int pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = effective_reqs + quota;
    while (effective_reqs < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        run_write_xfer();
      end else if (pick < 85) begin
        run_read_xfer();
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        repeat (BUF_DEPTH + 2) send_load(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_write_path();
    test_refusals_and_zero_read();
    test_repeated_start_and_errors();
    test_random_traffic(0, 0, 475);
    test_random_traffic(49, 0, 475);
    test_random_traffic(0, 49, 475);
    test_random_traffic(34, 34, 475);

    // Drop valid, drain outstanding results, then allow a few spare cycles.
    s_tvalid <= 1'b0;
    while (pending_responses.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/i2cms_pkg.sv
src/i2cms_ram.sv
src/i2c_master_transaction_sequencer_core.sv
tb/tb_i2c_master_transaction_sequencer_core.sv
